// ===== design/bounded_stack_sorted_insert_unit_defines.svh =====
// ============================================================================
// bounded_stack_sorted_insert_unit_defines.svh
// Assertion macros shared by the stack unit RTL.
// ============================================================================
`ifndef BOUNDED_STACK_SORTED_INSERT_UNIT_DEFINES_SVH
`define BOUNDED_STACK_SORTED_INSERT_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked on every rising edge out of reset
`define BSSI_ASSERT_IMP(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: implication failed");

// Next-cycle implication, checked on every rising edge out of reset
`define BSSI_ASSERT_NXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: next-cycle implication failed");

`else

`define BSSI_ASSERT_IMP(name, clk, rst_n, ante, cons)
`define BSSI_ASSERT_NXT(name, clk, rst_n, ante, cons)

`endif

`endif

// ===== design/bssi_pkg.sv =====
// ============================================================================
// bssi_pkg
// Widths, request and status codes of the bounded stack unit.
// ============================================================================
package bssi_pkg;

  localparam int DATA_W        = 32;
  localparam int REQ_W         = 2;
  localparam int STATUS_W      = 2;
  localparam int COUNT_W       = 6;
  localparam int TDATA_IN_W    = 32;
  localparam int TDATA_OUT_W   = 40;
  localparam int DEFAULT_DEPTH = 32;

  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH    = 2'd0,
    REQ_POP     = 2'd1,
    REQ_REVERSE = 2'd2,
    REQ_ORDERED = 2'd3
  } req_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

endpackage

// ===== design/bssi_ram.sv =====
// ============================================================================
// bssi_ram
// Generic simple dual-port RAM: one write port, one read port with the read
// data registered. Read data holds while rd_en is low.
// ============================================================================
module bssi_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== design/bounded_stack_sorted_insert_unit.sv =====
// ============================================================================
// bounded_stack_sorted_insert_unit
// Bounded LIFO stack of signed 32-bit words with push, pop, reverse and
// ordered push; one result item per request item.
// ============================================================================
// The stack lives in one RAM with one write and one registered read port, and
// the unit works on one item at a time. Each request ends in S_RESP. Push
// writes the RAM on accept, pop reads the top entry and captures it in
// S_POP_WAIT, reverse swaps the entries at lo and hi moving inward (each swap
// needs two reads and two writes through the single ports), and ordered push
// scans down from the top over the entries smaller than the new value (one
// read and one shifting write per entry), then writes the new value, at the
// bottom when every stored entry is smaller.
// A finished result sits in an output register, so the next item is accepted
// while it waits to be taken.
// Rejected requests (push or ordered push when full, pop when empty) leave the
// stack unchanged. The RAM needs no clearing after reset; only entries below
// the count are ever read.
// ============================================================================
`include "bounded_stack_sorted_insert_unit_defines.svh"

module bounded_stack_sorted_insert_unit
  import bssi_pkg::*;
#(
  parameter int DEPTH = DEFAULT_DEPTH
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // request channel
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [TDATA_IN_W-1:0]  in_tdata,   // [31:0] value
  input  logic [REQ_W-1:0]       in_tuser,   // [1:0] req_type
  // result channel
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [TDATA_OUT_W-1:0] out_tdata,  // [31:0] data, [37:32] count, [39:38] zero
  output logic [STATUS_W-1:0]    out_tuser   // [1:0] status
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_POP_WAIT,
    S_REV_RD_LO,
    S_REV_RD_HI,
    S_REV_WR_LO,
    S_REV_WR_HI,
    S_ORD_RD,
    S_ORD_CMP,
    S_RESP
  } state_t;

  state_t              state_r, state_nxt;
  logic [CW-1:0]       cnt_r, cnt_nxt;
  logic [AW-1:0]       lo_r, lo_nxt;
  logic [AW-1:0]       hi_r, hi_nxt;
  logic [AW-1:0]       pos_r, pos_nxt;
  logic [DATA_W-1:0]   val_r, val_nxt;
  logic [DATA_W-1:0]   tmp_r, tmp_nxt;
  logic [DATA_W-1:0]   res_data_r, res_data_nxt;
  status_t             res_status_r, res_status_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0]   out_data_r, out_data_nxt;
  status_t             out_status_r, out_status_nxt;
  logic [COUNT_W-1:0]  out_count_r, out_count_nxt;

  logic                mem_we;
  logic [AW-1:0]       mem_waddr;
  logic [DATA_W-1:0]   mem_wdata;
  logic                mem_re;
  logic [AW-1:0]       mem_raddr;
  logic [DATA_W-1:0]   mem_rdata;

  logic                in_acc;
  req_t                in_req;
  logic [DATA_W-1:0]   in_value;
  logic                full;
  logic                empty;
  logic [CW-1:0]       cnt_inc;
  logic [CW-1:0]       cnt_dec;
  logic [AW-1:0]       lo_inc;
  logic [AW-1:0]       hi_dec;
  logic [AW-1:0]       pos_dec;

  // stack storage
  bssi_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_en   (mem_re),
    .rd_addr (mem_raddr),
    .rd_data (mem_rdata)
  );

  // decode request and helpers
  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign in_req    = req_t'(in_tuser);
  assign in_value  = in_tdata[DATA_W-1:0];
  assign full      = (cnt_r == CW'(DEPTH));
  assign empty     = (cnt_r == '0);
  assign cnt_inc   = cnt_r + CW'(1);
  assign cnt_dec   = cnt_r - CW'(1);
  assign lo_inc    = lo_r + AW'(1);
  assign hi_dec    = hi_r - AW'(1);
  assign pos_dec   = pos_r - AW'(1);

  // sequencer: read, modify and write back through the RAM
  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    pos_nxt        = pos_r;
    val_nxt        = val_r;
    tmp_nxt        = tmp_r;
    res_data_nxt   = res_data_r;
    res_status_nxt = res_status_r;
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    out_status_nxt = out_status_r;
    out_count_nxt  = out_count_r;
    mem_we         = 1'b0;
    mem_waddr      = '0;
    mem_wdata      = '0;
    mem_re         = 1'b0;
    mem_raddr      = '0;

    // drop a result once taken
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          res_data_nxt   = '0;
          res_status_nxt = ST_OK;
          state_nxt      = S_RESP;
          case (in_req)
            REQ_PUSH: begin
              if (full) begin
                res_status_nxt = ST_FULL;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = cnt_r[AW-1:0];
                mem_wdata = in_value;
                cnt_nxt   = cnt_inc;
              end
            end
            REQ_POP: begin
              if (empty) begin
                res_data_nxt   = '1;
                res_status_nxt = ST_EMPTY;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = cnt_dec[AW-1:0];
                cnt_nxt   = cnt_dec;
                state_nxt = S_POP_WAIT;
              end
            end
            REQ_REVERSE: begin
              if (cnt_r > CW'(1)) begin
                lo_nxt    = '0;
                hi_nxt    = cnt_dec[AW-1:0];
                state_nxt = S_REV_RD_LO;
              end
            end
            REQ_ORDERED: begin
              if (full) begin
                res_status_nxt = ST_FULL;
              end else begin
                val_nxt   = in_value;
                pos_nxt   = cnt_r[AW-1:0];
                state_nxt = S_ORD_RD;
              end
            end
            default: begin
              state_nxt = S_RESP;
            end
          endcase
        end
      end

      // capture the popped word
      S_POP_WAIT: begin
        res_data_nxt = mem_rdata;
        state_nxt    = S_RESP;
      end

      // swap the entries at lo and hi
      S_REV_RD_LO: begin
        mem_re    = 1'b1;
        mem_raddr = lo_r;
        state_nxt = S_REV_RD_HI;
      end
      S_REV_RD_HI: begin
        mem_re    = 1'b1;
        mem_raddr = hi_r;
        tmp_nxt   = mem_rdata;
        state_nxt = S_REV_WR_LO;
      end
      S_REV_WR_LO: begin
        mem_we    = 1'b1;
        mem_waddr = lo_r;
        mem_wdata = mem_rdata;
        state_nxt = S_REV_WR_HI;
      end
      S_REV_WR_HI: begin
        mem_we    = 1'b1;
        mem_waddr = hi_r;
        mem_wdata = tmp_r;
        lo_nxt    = lo_inc;
        hi_nxt    = hi_dec;
        if (lo_inc < hi_dec) begin
          state_nxt = S_REV_RD_LO;
        end else begin
          state_nxt = S_RESP;
        end
      end

      // scan down, shifting smaller entries up by one
      S_ORD_RD: begin
        if (pos_r == '0) begin
          mem_we    = 1'b1;
          mem_waddr = pos_r;
          mem_wdata = val_r;
          cnt_nxt   = cnt_inc;
          state_nxt = S_RESP;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = pos_dec;
          state_nxt = S_ORD_CMP;
        end
      end
      S_ORD_CMP: begin
        mem_we    = 1'b1;
        mem_waddr = pos_r;
        if ($signed(mem_rdata) < $signed(val_r)) begin
          mem_wdata = mem_rdata;
          pos_nxt   = pos_dec;
          state_nxt = S_ORD_RD;
        end else begin
          mem_wdata = val_r;
          cnt_nxt   = cnt_inc;
          state_nxt = S_RESP;
        end
      end

      // hand the result to the output register when it is free
      S_RESP: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt  = 1'b1;
          out_data_nxt   = res_data_r;
          out_status_nxt = res_status_r;
          out_count_nxt  = COUNT_W'(cnt_r);
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      out_valid_r  <= out_valid_nxt;
      lo_r         <= lo_nxt;
      hi_r         <= hi_nxt;
      pos_r        <= pos_nxt;
      val_r        <= val_nxt;
      tmp_r        <= tmp_nxt;
      res_data_r   <= res_data_nxt;
      res_status_r <= res_status_nxt;
      out_data_r   <= out_data_nxt;
      out_status_r <= out_status_nxt;
      out_count_r  <= out_count_nxt;
    end
  end

  // drive the result channel
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(TDATA_OUT_W - COUNT_W - DATA_W)'(0), out_count_r, out_data_r};
  assign out_tuser  = out_status_r;

  // checks
  `BSSI_ASSERT_IMP(a_cnt_bound, clk, rst_n, 1'b1, cnt_r <= CW'(DEPTH))
  `BSSI_ASSERT_NXT(a_accept_busy, clk, rst_n, in_acc, state_r != S_IDLE)
  `BSSI_ASSERT_NXT(a_push_count, clk, rst_n,
                   in_acc && in_req == REQ_PUSH && !full, cnt_r == $past(cnt_inc))
  `BSSI_ASSERT_IMP(a_rev_order, clk, rst_n, state_r == S_REV_RD_LO, lo_r < hi_r)
  `BSSI_ASSERT_IMP(a_resp_slot, clk, rst_n,
                   out_valid_r && !out_tready && state_r == S_RESP, state_nxt == S_RESP)

endmodule
